// ===== hdl/lich_pkg.sv =====
`default_nettype none

package lich_pkg;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    SEG_NS,
    SEG_COLON,
    SEG_NM
  } seg_kind_t;

  // one classified byte on its way from front to back
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       bad;
    seg_kind_t  kind;
  } beat_t;

endpackage

`default_nettype wire

// ===== hdl/lich_front.sv =====
`default_nettype none

module lich_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire logic [7:0]    ch,
  input  wire logic          is_last,
  output lich_pkg::beat_t    beat
);
  import lich_pkg::*;

  logic in_name;
  logic started;
  logic is_lower, is_upper, is_digit, is_punct, is_colon;

  always_comb begin
    is_lower = (ch >= 8'h61) && (ch <= 8'h7A);
    is_upper = (ch >= 8'h41) && (ch <= 8'h5A);
    is_digit = (ch >= 8'h30) && (ch <= 8'h39);
    is_punct = (ch == 8'h5F) || (ch == 8'h2D) || (ch == 8'h2E);
    is_colon = (ch == 8'h3A);
  end

  always_comb begin
    beat.ch   = ch;
    beat.last = is_last;
    if (!in_name) begin
      if (is_colon) begin
        beat.kind = SEG_COLON;
        beat.bad  = 1'b0;
      end else begin
        beat.kind = SEG_NS;
        beat.bad  = !(is_lower || is_digit || is_punct) || (!started && !is_lower);
      end
    end else begin
      beat.kind = SEG_NM;
      beat.bad  = !(is_lower || is_upper || is_digit || is_punct) ||
                  (!started && !(is_lower || is_upper || is_digit));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_name <= 1'b0;
      started <= 1'b0;
    end else if (push) begin
      if (is_last) begin
        in_name <= 1'b0;
        started <= 1'b0;
      end else if (!in_name && is_colon) begin
        in_name <= 1'b1;
        started <= 1'b0;
      end else begin
        started <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    push && is_last |=> !in_name && !started)
    else $error("front state not cleared after last beat");
`endif

endmodule

`default_nettype wire

// ===== hdl/lich_queue.sv =====
`default_nettype none

module lich_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire lich_pkg::beat_t wr_beat,
  input  wire logic          pop,
  output lich_pkg::beat_t    rd_beat,
  output logic               not_empty,
  output logic               full
);
  import lich_pkg::*;

  beat_t                mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   count;

  assign rd_beat   = mem[rd_ptr];
  assign not_empty = (count != '0);
  assign full      = (count == Q_CNT_W'(Q_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full || pop)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

// ===== hdl/lich_back.sv =====
`default_nettype none

module lich_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_valid,
  input  wire lich_pkg::beat_t q_beat,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic                 valid_res,
  output logic [63:0]          id_hash,
  output logic [15:0]          namespace_length,
  output logic [15:0]          name_length
);
  import lich_pkg::*;

  localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;

  logic [63:0] running_hash;
  logic        in_name_part;
  logic        seen_bad;
  logic [15:0] ns_count;
  logic [15:0] nm_count;

  logic [63:0] hash_x;
  logic [63:0] hash_next;
  logic        in_name_next;
  logic        seen_bad_next;
  logic [15:0] ns_count_next;
  logic [15:0] nm_count_next;

  assign q_pop = q_valid && (!q_beat.last || !out_valid || !out_stall);

  // prime = 2^40 + 0x1b3, so the multiply is a constant shift-add
  always_comb begin
    hash_x    = running_hash ^ {56'd0, q_beat.ch};
    hash_next = (hash_x << 40) + (hash_x << 8) + (hash_x << 7) + (hash_x << 5) +
                (hash_x << 4) + (hash_x << 1) + hash_x;
  end

  always_comb begin
    in_name_next  = in_name_part;
    ns_count_next = ns_count;
    nm_count_next = nm_count;
    seen_bad_next = seen_bad || q_beat.bad;
    case (q_beat.kind)
      SEG_NS:    ns_count_next = ns_count + 16'(ns_count != 16'hFFFF);
      SEG_COLON: in_name_next  = 1'b1;
      SEG_NM:    nm_count_next = nm_count + 16'(nm_count != 16'hFFFF);
      default:   in_name_next  = in_name_part;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= FNV_BASIS;
      in_name_part <= 1'b0;
      seen_bad     <= 1'b0;
      ns_count     <= '0;
      nm_count     <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (q_pop && q_beat.last) begin
        running_hash <= FNV_BASIS;
        in_name_part <= 1'b0;
        seen_bad     <= 1'b0;
        ns_count     <= '0;
        nm_count     <= '0;
        out_valid    <= 1'b1;
      end else begin
        if (q_pop) begin
          running_hash <= hash_next;
          in_name_part <= in_name_next;
          seen_bad     <= seen_bad_next;
          ns_count     <= ns_count_next;
          nm_count     <= nm_count_next;
        end
        if (!out_stall) begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_beat.last) begin
      valid_res        <= !seen_bad_next && in_name_next &&
                          (ns_count_next != '0) && (nm_count_next != '0);
      id_hash          <= hash_next;
      namespace_length <= ns_count_next;
      name_length      <= nm_count_next;
    end
  end

`ifndef SYNTHESIS
  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !(q_pop && q_beat.last))
    else $error("held result overwritten");
  a_restart_after_last: assert property (@(posedge clk) disable iff (rst)
    q_pop && q_beat.last |=> running_hash == FNV_BASIS && !in_name_part &&
                             !seen_bad && ns_count == '0 && nm_count == '0)
    else $error("back state not reset after last beat");
`endif

endmodule

`default_nettype wire

// ===== hdl/logical_id_check_and_hash.sv =====
// channel | beat                                       | handshake
// in      | ch[7:0], is_last                           | in_valid / in_stall
// out     | valid_res, id_hash[63:0], namespace_length, | out_valid / out_stall
//         | name_length                                |
// One byte per cycle unless a result is held; the back-end FNV shift-add is the loop.
// With the queue empty the last byte passes a queue entry, then the out_valid register.
// in_stall is high while the two-entry queue is full; out_stall holds the result register.
// Synchronous active-high rst returns front, queue and back end to the empty string.
`default_nettype none

module logical_id_check_and_hash (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  ch,
  input  wire logic        is_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             valid_res,
  output logic [63:0]      id_hash,
  output logic [15:0]      namespace_length,
  output logic [15:0]      name_length
);
  import lich_pkg::*;

  logic  push;
  logic  pop;
  logic  q_not_empty;
  logic  q_full;
  beat_t fr_beat;
  beat_t q_beat;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  lich_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .ch      (ch),
    .is_last (is_last),
    .beat    (fr_beat)
  );

  lich_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_beat   (fr_beat),
    .pop       (pop),
    .rd_beat   (q_beat),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  lich_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_valid          (q_not_empty),
    .q_beat           (q_beat),
    .q_pop            (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .valid_res        (valid_res),
    .id_hash          (id_hash),
    .namespace_length (namespace_length),
    .name_length      (name_length)
  );

endmodule

`default_nettype wire
